/* rtl/bsf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box sum filter package
// Shared widths, register indexes, reset values and the per-item control
// record that travels from the position sequencer to the sum datapath.
// ----------------------------------------------------------------------------
package bsf_pkg;

  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_RADIUS_DEF = 15;
  localparam int MAX_HEIGHT     = 4096;

  localparam int CFG_DW = 13;
  localparam int CFG_IW = 2;

  localparam logic [CFG_IW-1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_IW-1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [CFG_IW-1:0] REG_WINDOW_RADIUS = 2'd2;

  localparam int RESET_WIDTH  = 4096;
  localparam int RESET_HEIGHT = 4096;
  localparam int RESET_RADIUS = 8;

  localparam int PIX_W     = 8;
  localparam int COL_SUM_W = 13;
  localparam int BOX_SUM_W = 18;
  localparam int OUT_POS_W = 12;
  localparam int ROW_W     = 13;
  localparam int RADIUS_IN_W = 4;

  typedef struct packed {
    logic [PIX_W-1:0]     pix;
    logic                 in_col;
    logic                 first_row;
    logic                 drop_ok;
    logic                 leave_ok;
    logic                 row_start;
    logic                 out_ok;
    logic                 last;
    logic [OUT_POS_W-1:0] out_col;
    logic [OUT_POS_W-1:0] out_row;
  } item_info_t;

endpackage

/* rtl/bsf_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box sum filter position sequencer
// Holds the configuration and the extended raster position, and derives the
// memory addresses and per-item flags for each accepted item.
// ----------------------------------------------------------------------------
module bsf_ctrl #(
  parameter int MAX_WIDTH  = bsf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_RADIUS = bsf_pkg::MAX_RADIUS_DEF,
  localparam int XW  = $clog2(MAX_WIDTH + MAX_RADIUS),
  localparam int RW  = $clog2(MAX_RADIUS + 1),
  localparam int TW  = RW + 1,
  localparam int CAW = $clog2(MAX_WIDTH),
  localparam int LAW = $clog2((2 * MAX_RADIUS + 1) * MAX_WIDTH)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bsf_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [bsf_pkg::CFG_DW-1:0]    cfg_data,
  input  logic                          advance,
  input  logic [bsf_pkg::PIX_W-1:0]     pixel_value,
  output bsf_pkg::item_info_t           info,
  output logic [CAW-1:0]                col_addr,
  output logic [LAW-1:0]                line_addr,
  output logic [TW-1:0]                 tap_sel
);

  localparam int RESET_W = (bsf_pkg::RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH
                                                             : bsf_pkg::RESET_WIDTH;
  localparam int RESET_R = (bsf_pkg::RESET_RADIUS > MAX_RADIUS) ? MAX_RADIUS
                                                               : bsf_pkg::RESET_RADIUS;

  logic [XW-1:0]                 img_width;
  logic [bsf_pkg::ROW_W-1:0]     img_height;
  logic [RW-1:0]                 radius;
  logic [XW-1:0]                 pos_col;
  logic [bsf_pkg::ROW_W-1:0]     pos_row;
  logic [TW-1:0]                 slot;
  logic [LAW-1:0]                line_base;

  logic        cfg_hit;
  logic [31:0] x32, y32, w32, h32, r32, cfg32, rad32;
  logic        in_col, col_end, row_end;

  always_comb begin
    cfg_hit = cfg_we && ((cfg_index == bsf_pkg::REG_IMAGE_WIDTH) ||
                         (cfg_index == bsf_pkg::REG_IMAGE_HEIGHT) ||
                         (cfg_index == bsf_pkg::REG_WINDOW_RADIUS));
    cfg32 = 32'(cfg_data);
    rad32 = 32'(cfg_data[bsf_pkg::RADIUS_IN_W-1:0]);
    x32 = 32'(pos_col);
    y32 = 32'(pos_row);
    w32 = 32'(img_width);
    h32 = 32'(img_height);
    r32 = 32'(radius);
    in_col  = x32 < w32;
    col_end = x32 == (w32 + r32 - 32'd1);
    row_end = y32 == (h32 + r32 - 32'd1);
    tap_sel = {radius, 1'b0};

    info.pix       = (in_col && (y32 < h32)) ? pixel_value : '0;
    info.in_col    = in_col;
    info.first_row = (pos_row == '0);
    info.drop_ok   = y32 > (r32 << 1);
    info.leave_ok  = x32 > (r32 << 1);
    info.row_start = (pos_col == '0);
    info.out_ok    = (x32 >= r32) && (y32 >= r32);
    info.last      = col_end && row_end;
    info.out_col   = bsf_pkg::OUT_POS_W'(x32 - r32);
    info.out_row   = bsf_pkg::OUT_POS_W'(y32 - r32);

    col_addr  = pos_col[CAW-1:0];
    line_addr = line_base + LAW'(pos_col);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      img_width  <= XW'(RESET_W);
      img_height <= bsf_pkg::ROW_W'(bsf_pkg::RESET_HEIGHT);
      radius     <= RW'(RESET_R);
    end else if (cfg_we) begin
      case (cfg_index)
        bsf_pkg::REG_IMAGE_WIDTH: begin
          if (cfg_data == '0) begin
            img_width <= XW'(1);
          end else if (cfg32 > MAX_WIDTH) begin
            img_width <= XW'(MAX_WIDTH);
          end else begin
            img_width <= XW'(cfg_data);
          end
        end
        bsf_pkg::REG_IMAGE_HEIGHT: begin
          if (cfg_data == '0) begin
            img_height <= bsf_pkg::ROW_W'(1);
          end else if (cfg32 > bsf_pkg::MAX_HEIGHT) begin
            img_height <= bsf_pkg::ROW_W'(bsf_pkg::MAX_HEIGHT);
          end else begin
            img_height <= cfg_data;
          end
        end
        bsf_pkg::REG_WINDOW_RADIUS: begin
          if (rad32 > MAX_RADIUS) begin
            radius <= RW'(MAX_RADIUS);
          end else begin
            radius <= RW'(rad32);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      pos_col   <= '0;
      pos_row   <= '0;
      slot      <= '0;
      line_base <= '0;
    end else if (advance) begin
      if (col_end) begin
        pos_col <= '0;
        if (row_end) begin
          pos_row   <= '0;
          slot      <= '0;
          line_base <= '0;
        end else begin
          pos_row <= pos_row + 1'b1;
          if (slot == tap_sel) begin
            slot      <= '0;
            line_base <= '0;
          end else begin
            slot      <= slot + 1'b1;
            line_base <= line_base + LAW'(MAX_WIDTH);
          end
        end
      end else begin
        pos_col <= pos_col + 1'b1;
      end
    end
  end

endmodule

/* rtl/bsf_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box sum filter datapath
// Line and column-sum memories with read-modify-write and forwarding, the
// horizontal running sum with its column delay line, and the output register.
// ----------------------------------------------------------------------------
module bsf_dp #(
  parameter int MAX_WIDTH  = bsf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_RADIUS = bsf_pkg::MAX_RADIUS_DEF,
  localparam int RW   = $clog2(MAX_RADIUS + 1),
  localparam int TW   = RW + 1,
  localparam int CAW  = $clog2(MAX_WIDTH),
  localparam int LINE_DEPTH = (2 * MAX_RADIUS + 1) * MAX_WIDTH,
  localparam int LAW  = $clog2(LINE_DEPTH),
  localparam int TAPS = 2 * MAX_RADIUS + 1
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              advance,
  input  bsf_pkg::item_info_t               info_in,
  input  logic [CAW-1:0]                    col_addr,
  input  logic [LAW-1:0]                    line_addr,
  input  logic [TW-1:0]                     tap_sel,
  output logic                              s1_free,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [bsf_pkg::BOX_SUM_W-1:0]     box_sum,
  output logic [bsf_pkg::OUT_POS_W-1:0]     out_col,
  output logic [bsf_pkg::OUT_POS_W-1:0]     out_row,
  output logic                              frame_last
);

  logic [bsf_pkg::COL_SUM_W-1:0] col_mem [MAX_WIDTH];
  logic [bsf_pkg::PIX_W-1:0]     line_mem [LINE_DEPTH];
  logic [bsf_pkg::COL_SUM_W-1:0] col_rd;
  logic [bsf_pkg::PIX_W-1:0]     line_rd;

  logic                          s1_valid;
  bsf_pkg::item_info_t           s1;
  logic [CAW-1:0]                s1_col_addr;
  logic [LAW-1:0]                s1_line_addr;

  logic                          fwd_col_hit;
  logic                          fwd_line_hit;
  logic [bsf_pkg::COL_SUM_W-1:0] fwd_col_data;
  logic [bsf_pkg::PIX_W-1:0]     fwd_line_data;

  logic [bsf_pkg::COL_SUM_W-1:0] taps [TAPS];
  logic [bsf_pkg::BOX_SUM_W-1:0] hsum;

  logic                          s1_done, s1_wr;
  logic [bsf_pkg::COL_SUM_W-1:0] prev, col_sum, incoming, leaving;
  logic [bsf_pkg::PIX_W-1:0]     dropped;
  logic [bsf_pkg::BOX_SUM_W-1:0] hsum_base, hsum_next;

  always_comb begin
    s1_done  = s1_valid && (!s1.out_ok || !out_valid || !out_stall);
    s1_free  = !s1_valid || s1_done;
    s1_wr    = s1_done && s1.in_col;
    prev     = s1.first_row ? '0 : (fwd_col_hit ? fwd_col_data : col_rd);
    dropped  = s1.drop_ok ? (fwd_line_hit ? fwd_line_data : line_rd) : '0;
    col_sum  = prev + bsf_pkg::COL_SUM_W'(s1.pix) - bsf_pkg::COL_SUM_W'(dropped);
    incoming = s1.in_col ? col_sum : '0;
    leaving  = s1.leave_ok ? taps[tap_sel] : '0;
    hsum_base = s1.row_start ? '0 : hsum;
    hsum_next = hsum_base + bsf_pkg::BOX_SUM_W'(incoming)
                - bsf_pkg::BOX_SUM_W'(leaving);
  end

  always_ff @(posedge clk) begin
    if (s1_wr) begin
      col_mem[s1_col_addr] <= col_sum;
    end
    if (advance) begin
      col_rd <= col_mem[col_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_wr) begin
      line_mem[s1_line_addr] <= s1.pix;
    end
    if (advance) begin
      line_rd <= line_mem[line_addr];
    end
  end

  // A read issued while the previous item writes the same entry sees the old
  // data, so the written value is captured alongside the read.
  always_ff @(posedge clk) begin
    if (advance) begin
      s1            <= info_in;
      s1_col_addr   <= col_addr;
      s1_line_addr  <= line_addr;
      fwd_col_hit   <= s1_wr && (s1_col_addr == col_addr);
      fwd_line_hit  <= s1_wr && (s1_line_addr == line_addr);
      fwd_col_data  <= col_sum;
      fwd_line_data <= s1.pix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= 1'b1;
    end else if (s1_done) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hsum <= '0;
    end else if (s1_done) begin
      hsum <= hsum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_done) begin
      taps[0] <= incoming;
      for (int i = 1; i < TAPS; i++) begin
        taps[i] <= taps[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_done && s1.out_ok) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_done && s1.out_ok) begin
      box_sum    <= hsum_next;
      out_col    <= s1.out_col;
      out_row    <= s1.out_row;
      frame_last <= s1.last;
    end
  end

endmodule

/* rtl/box_sum_filter_2d.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box sum filter, two-dimensional
// The input channel (in_valid, in_stall, pixel_value) takes one 8-bit pixel
// per item in raster order over an extended frame of (width + R) columns by
// (height + R) rows; pixels beyond the image are ignored and count as zero.
// The output channel (out_valid, out_stall) gives box_sum, the sum of all
// in-image pixels in the (2R+1) square around (out_col, out_row), once for
// every image pixel, with frame_last on the final result of a frame.
// The configuration port (cfg_we, cfg_index, cfg_data) sets width, height and
// radius; a write to one of these registers restarts the frame at position (0,0).
// The memories are read at the accepting clock edge, and the sum is registered
// in the output register when the sum stage completes the item. The block
// takes one item per clock while the input is not stalled, set by the
// read-modify-write of the line and column-sum memories, which each take one
// read and one write per cycle.
// Reset restores width 4096, height 4096, radius 8, position (0,0) and an
// empty pipeline; the memories need no clearing pass.
// While the receiver stalls, the output register holds its result and one more
// item waits in the sum stage; after that the input is stalled.
// ----------------------------------------------------------------------------
module box_sum_filter_2d #(
  parameter int MAX_WIDTH  = bsf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_RADIUS = bsf_pkg::MAX_RADIUS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [bsf_pkg::CFG_IW-1:0]        cfg_index,
  input  logic [bsf_pkg::CFG_DW-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [bsf_pkg::PIX_W-1:0]         pixel_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [bsf_pkg::BOX_SUM_W-1:0]     box_sum,
  output logic [bsf_pkg::OUT_POS_W-1:0]     out_col,
  output logic [bsf_pkg::OUT_POS_W-1:0]     out_row,
  output logic                              frame_last
);

  localparam int RW  = $clog2(MAX_RADIUS + 1);
  localparam int TW  = RW + 1;
  localparam int CAW = $clog2(MAX_WIDTH);
  localparam int LAW = $clog2((2 * MAX_RADIUS + 1) * MAX_WIDTH);

  bsf_pkg::item_info_t info;
  logic [CAW-1:0]      col_addr;
  logic [LAW-1:0]      line_addr;
  logic [TW-1:0]       tap_sel;
  logic                s1_free;
  logic                in_fire;

  assign in_stall = !s1_free;
  assign in_fire  = in_valid && s1_free;

  bsf_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .advance     (in_fire),
    .pixel_value (pixel_value),
    .info        (info),
    .col_addr    (col_addr),
    .line_addr   (line_addr),
    .tap_sel     (tap_sel)
  );

  bsf_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .advance    (in_fire),
    .info_in    (info),
    .col_addr   (col_addr),
    .line_addr  (line_addr),
    .tap_sel    (tap_sel),
    .s1_free    (s1_free),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .box_sum    (box_sum),
    .out_col    (out_col),
    .out_row    (out_row),
    .frame_last (frame_last)
  );

endmodule

/* rtl/bsf_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box sum filter port checker
// Checks reset, stall and latency behavior as seen on the top-level ports.
// ----------------------------------------------------------------------------
module bsf_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [bsf_pkg::BOX_SUM_W-1:0]     box_sum,
  input logic [bsf_pkg::OUT_POS_W-1:0]     out_col,
  input logic [bsf_pkg::OUT_POS_W-1:0]     out_row,
  input logic                              frame_last
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled output");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result appeared without an item two edges earlier");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(box_sum) && $stable(out_col)
                                  && $stable(out_row) && $stable(frame_last)))
    else $error("stalled result changed");

endmodule

bind box_sum_filter_2d bsf_checker u_bsf_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .box_sum    (box_sum),
  .out_col    (out_col),
  .out_row    (out_row),
  .frame_last (frame_last)
);

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the two-dimensional box sum filter
// Streams extended raster frames into box_sum_filter_2d and checks every
// result against a cycle-free predictor of the window sums kept in this
// file. A short scripted part covers reset values, pixel extremes, zero and
// oversized dimensions, ignored border items and an unmapped register. It is
// followed by a full frame of saturated pixels at the largest radius, the
// start of a widest row and of a tallest column, and randomly sized frames.
// Both channels idle at random, and the receiver once holds off long enough
// to back up the input.
// ----------------------------------------------------------------------------
module testbench;

  localparam int MAX_W = bsf_pkg::MAX_WIDTH_DEF;
  localparam int MAX_R = bsf_pkg::MAX_RADIUS_DEF;
  localparam int MAX_H = bsf_pkg::MAX_HEIGHT;
  localparam int CFG_IW = bsf_pkg::CFG_IW;
  localparam int CFG_DW = bsf_pkg::CFG_DW;
  localparam int PIX_W = bsf_pkg::PIX_W;
  localparam int COL_SUM_W = bsf_pkg::COL_SUM_W;
  localparam int BOX_SUM_W = bsf_pkg::BOX_SUM_W;
  localparam int OUT_POS_W = bsf_pkg::OUT_POS_W;
  localparam int RADIUS_IN_W = bsf_pkg::RADIUS_IN_W;
  localparam logic [CFG_IW-1:0] REG_IMAGE_WIDTH = bsf_pkg::REG_IMAGE_WIDTH;
  localparam logic [CFG_IW-1:0] REG_IMAGE_HEIGHT = bsf_pkg::REG_IMAGE_HEIGHT;
  localparam logic [CFG_IW-1:0] REG_WINDOW_RADIUS = bsf_pkg::REG_WINDOW_RADIUS;
  localparam int LINE_SLOTS = 2 * MAX_R + 1;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int NUM_SCRIPT_ROWS = 36;
  localparam int SHORT_RUN = 12;
  localparam int RANDOM_ITEMS = 80;
  localparam logic [CFG_IW-1:0] REG_UNMAPPED = 2'd3;

  typedef struct packed {
    logic [BOX_SUM_W-1:0] sum;
    logic [OUT_POS_W-1:0] col;
    logic [OUT_POS_W-1:0] row;
    logic last;
  } box_result_t;

  typedef enum logic {ROW_REG, ROW_PIX} row_kind_e;
  typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_GIVEN} row_check_e;

  typedef struct packed {
    row_kind_e kind;
    logic [CFG_IW-1:0] reg_idx;
    logic [CFG_DW-1:0] reg_val;
    logic [PIX_W-1:0] pix;
    row_check_e check;
    box_result_t want;
  } script_row_t;

  logic clk;
  logic rst = 1'b1;
  logic cfg_we;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic [PIX_W-1:0] pixel_value;
  logic out_valid;
  logic out_stall;
  logic [BOX_SUM_W-1:0] box_sum;
  logic [OUT_POS_W-1:0] out_col;
  logic [OUT_POS_W-1:0] out_row;
  logic frame_last;

  logic [CFG_DW-1:0] img_w;
  logic [CFG_DW-1:0] img_h;
  logic [RADIUS_IN_W-1:0] win_r;
  logic [PIX_W-1:0] line_mem [LINE_SLOTS*MAX_W];
  logic [COL_SUM_W-1:0] col_sum_mem [MAX_W];
  logic [BOX_SUM_W-1:0] row_acc;
  int unsigned pos_x;
  int unsigned pos_y;

  box_result_t expected_sums[$];
  int error_count = 0;
  int cycle_count = 0;
  bit no_gap = 1'b0;
  bit hold_off_req = 1'b0;

  script_row_t script_rows [NUM_SCRIPT_ROWS] = '{
    '{ROW_PIX, REG_IMAGE_WIDTH, 13'd0, 8'hFF, EXP_NONE, '0},
    '{ROW_PIX, REG_IMAGE_WIDTH, 13'd0, 8'h00, EXP_NONE, '0},
    '{ROW_REG, REG_IMAGE_WIDTH, 13'd1, 8'h00, EXP_NONE, '0},
    '{ROW_REG, REG_IMAGE_HEIGHT, 13'd1, 8'h00, EXP_NONE, '0},
    '{ROW_REG, REG_WINDOW_RADIUS, 13'd0, 8'h00, EXP_NONE, '0},
    '{ROW_PIX, REG_IMAGE_WIDTH, 13'd0, 8'hFF, EXP_GIVEN, '{18'd255, 12'd0, 12'd0, 1'b1}},
    '{ROW_PIX, REG_IMAGE_WIDTH, 13'd0, 8'h00, EXP_GIVEN, '{18'd0, 12'd0, 12'd0, 1'b1}},
    '{ROW_REG, REG_IMAGE_WIDTH, 13'd0, 8'h00, EXP_NONE, '0},
    '{ROW_REG, REG_IMAGE_HEIGHT, 13'd0, 8'h00, EXP_NONE, '0},
    '{ROW_PIX, REG_IMAGE_WIDTH, 13'd0, 8'hC8, EXP_GIVEN, '{18'd200, 12'd0, 12'd0, 1'b1}},
    '{ROW_REG, REG_IMAGE_WIDTH, 13'd1, 8'h00, EXP_NONE, '0},
    '{ROW_REG, REG_IMAGE_HEIGHT, 13'd1, 8'h00, EXP_NONE, '0},
    '{ROW_REG, REG_WINDOW_RADIUS, 13'd1, 8'h00, EXP_NONE, '0},
    '{ROW_PIX, REG_IMAGE_WIDTH, 13'd0, 8'h07, EXP_NONE, '0},
    '{ROW_PIX, REG_IMAGE_WIDTH, 13'd0, 8'h63, EXP_NONE, '0},
    '{ROW_PIX, REG_IMAGE_WIDTH, 13'd0, 8'h37, EXP_NONE, '0},
    '{ROW_PIX, REG_IMAGE_WIDTH, 13'd0, 8'h80, EXP_GIVEN, '{18'd7, 12'd0, 12'd0, 1'b1}},
    '{ROW_REG, REG_IMAGE_WIDTH, 13'd2, 8'h00, EXP_NONE, '0},
    '{ROW_REG, REG_IMAGE_HEIGHT, 13'd2, 8'h00, EXP_NONE, '0},
    '{ROW_PIX, REG_IMAGE_WIDTH, 13'd0, 8'h01, EXP_MODEL, '0},
    '{ROW_PIX, REG_IMAGE_WIDTH, 13'd0, 8'h80, EXP_MODEL, '0},
    '{ROW_PIX, REG_IMAGE_WIDTH, 13'd0, 8'hFE, EXP_MODEL, '0},
    '{ROW_PIX, REG_IMAGE_WIDTH, 13'd0, 8'h7F, EXP_MODEL, '0},
    '{ROW_REG, REG_UNMAPPED, 13'h1FFF, 8'h00, EXP_NONE, '0},
    '{ROW_PIX, REG_IMAGE_WIDTH, 13'd0, 8'h55, EXP_MODEL, '0},
    '{ROW_PIX, REG_IMAGE_WIDTH, 13'd0, 8'hAA, EXP_MODEL, '0},
    '{ROW_PIX, REG_IMAGE_WIDTH, 13'd0, 8'h10, EXP_MODEL, '0},
    '{ROW_PIX, REG_IMAGE_WIDTH, 13'd0, 8'h20, EXP_MODEL, '0},
    '{ROW_PIX, REG_IMAGE_WIDTH, 13'd0, 8'h30, EXP_MODEL, '0},
    '{ROW_REG, REG_IMAGE_WIDTH, 13'd4096, 8'h00, EXP_NONE, '0},
    '{ROW_REG, REG_IMAGE_HEIGHT, 13'd8191, 8'h00, EXP_NONE, '0},
    '{ROW_REG, REG_WINDOW_RADIUS, 13'd15, 8'h00, EXP_NONE, '0},
    '{ROW_PIX, REG_IMAGE_WIDTH, 13'd0, 8'hFF, EXP_NONE, '0},
    '{ROW_PIX, REG_IMAGE_WIDTH, 13'd0, 8'hFF, EXP_NONE, '0},
    '{ROW_REG, REG_IMAGE_WIDTH, 13'd8191, 8'h00, EXP_NONE, '0},
    '{ROW_PIX, REG_IMAGE_WIDTH, 13'd0, 8'h01, EXP_NONE, '0}
  };

  box_sum_filter_2d DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .pixel_value(pixel_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .box_sum(box_sum),
    .out_col(out_col),
    .out_row(out_row),
    .frame_last(frame_last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int unsigned clamp_dim(logic [CFG_DW-1:0] val, int unsigned top);
    if (val == 0) return 1;
    if (32'(val) > top) return top;
    return 32'(val);
  endfunction

  function automatic void apply_reg_write(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
    case (idx)
      REG_IMAGE_WIDTH: img_w = val;
      REG_IMAGE_HEIGHT: img_h = val;
      REG_WINDOW_RADIUS: win_r = val[RADIUS_IN_W-1:0];
      default: return;
    endcase
    row_acc = '0;
    pos_x = 0;
    pos_y = 0;
  endfunction

  function automatic bit predict_box_sum(logic [PIX_W-1:0] pix_in, output box_result_t res);
    int unsigned w, h, r, span, x, y, pix, incoming, leaving, idx, dropped, prev, acc;
    logic [COL_SUM_W-1:0] cs;
    bit hit;
    w = clamp_dim(img_w, MAX_W);
    h = clamp_dim(img_h, MAX_H);
    r = (32'(win_r) > MAX_R) ? MAX_R : 32'(win_r);
    span = 2 * r + 1;
    x = pos_x;
    y = pos_y;
    pix = 0;
    incoming = 0;
    leaving = 0;
    res = '0;
    hit = 1'b0;
    if (x < w && y < h) pix = 32'(pix_in);
    if (x < w) begin
      idx = (y % span) * MAX_W + x;
      dropped = (y >= span) ? 32'(line_mem[idx]) : 0;
      prev = (y == 0) ? 0 : 32'(col_sum_mem[x]);
      cs = COL_SUM_W'(prev + pix - dropped);
      line_mem[idx] = PIX_W'(pix);
      col_sum_mem[x] = cs;
      incoming = 32'(cs);
    end
    if (x >= span && x - span < w) leaving = 32'(col_sum_mem[x - span]);
    if (x == 0) row_acc = '0;
    acc = 32'(row_acc) + incoming - leaving;
    row_acc = BOX_SUM_W'(acc);
    if (x >= r && y >= r) begin
      res.sum = row_acc;
      res.col = OUT_POS_W'(x - r);
      res.row = OUT_POS_W'(y - r);
      res.last = (x == w + r - 1) && (y == h + r - 1);
      hit = 1'b1;
    end
    x++;
    if (x >= w + r) begin
      x = 0;
      y++;
      if (y >= h + r) y = 0;
    end
    pos_x = x;
    pos_y = y;
    return hit;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      error_count++;
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    box_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_sums.size() == 0) begin
        error_count++;
        $error("unexpected result at column %0d row %0d", out_col, out_row);
      end else begin
        want = expected_sums.pop_front();
        check_field("box_sum", 32'(want.sum), 32'(box_sum));
        check_field("out_col", 32'(want.col), 32'(out_col));
        check_field("out_row", 32'(want.row), 32'(out_row));
        check_field("frame_last", 32'(want.last), 32'(frame_last));
      end
    end
  end

  initial begin
    int seg;
    int pick;
    out_stall = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      pick = $urandom_range(0, 99);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        seg = 400;
      end else if (pick < 45) begin
        out_stall <= 1'b0;
        seg = $urandom_range(1, 12);
      end else if (pick < 85) begin
        out_stall <= 1'b1;
        seg = $urandom_range(1, 3);
      end else if (pick < 93) begin
        out_stall <= 1'b1;
        seg = $urandom_range(4, 15);
      end else if (pick < 96) begin
        out_stall <= 1'b1;
        seg = $urandom_range(20, 60);
      end else begin
        out_stall <= 1'b0;
        seg = $urandom_range(100, 300);
      end
      repeat (seg) @(posedge clk);
    end
  end

  task automatic offer_pixel(logic [PIX_W-1:0] pix);
    int gap;
    int pick;
    pick = $urandom_range(0, 99);
    if (no_gap || pick < 60) gap = 0;
    else if (pick < 90) gap = $urandom_range(1, 3);
    else if (pick < 98) gap = $urandom_range(4, 10);
    else gap = $urandom_range(20, 50);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel_value <= pix;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic feed_pixel(logic [PIX_W-1:0] pix);
    box_result_t res;
    offer_pixel(pix);
    if (predict_box_sum(pix, res)) expected_sums.push_back(res);
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
    in_valid <= 1'b0;
    while (expected_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    apply_reg_write(idx, val);
  endtask

  task automatic run_phase(logic [CFG_DW-1:0] w, logic [CFG_DW-1:0] h,
                           logic [CFG_DW-1:0] rad, int count, bit all_max);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_WINDOW_RADIUS, rad);
    for (int i = 0; i < count; i++)
      feed_pixel(all_max ? 8'hFF : PIX_W'($urandom_range(0, 255)));
  endtask

  initial begin
    bit got;
    box_result_t res;
    logic [CFG_DW-1:0] w_data, h_data, r_data;
    int unsigned ew, eh, r_val, frame_len;
    int count, sel, random_items;
    in_valid = 1'b0;
    pixel_value = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    img_w = CFG_DW'(bsf_pkg::RESET_WIDTH);
    img_h = CFG_DW'(bsf_pkg::RESET_HEIGHT);
    win_r = RADIUS_IN_W'(bsf_pkg::RESET_RADIUS);
    row_acc = '0;
    pos_x = 0;
    pos_y = 0;
    random_items = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_SCRIPT_ROWS; i++) begin
      if (script_rows[i].kind == ROW_REG) begin
        write_reg(script_rows[i].reg_idx, script_rows[i].reg_val);
      end else begin
        offer_pixel(script_rows[i].pix);
        got = predict_box_sum(script_rows[i].pix, res);
        case (script_rows[i].check)
          EXP_GIVEN: expected_sums.push_back(script_rows[i].want);
          EXP_MODEL: if (got) expected_sums.push_back(res);
          default: ;
        endcase
      end
    end

    hold_off_req = 1'b1;
    run_phase(13'd2, 13'd2, 13'd15, 17 * 17, 1'b1);
    run_phase(13'd8191, 13'd0, 13'd0, SHORT_RUN, 1'b0);
    run_phase(13'd1, 13'd4096, 13'd0, SHORT_RUN, 1'b0);

    while (random_items < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 19);
      if (sel == 0) w_data = '0;
      else if (sel == 1) w_data = CFG_DW'($urandom_range(4096, 8191));
      else if (sel < 6) w_data = CFG_DW'($urandom_range(9, 40));
      else w_data = CFG_DW'($urandom_range(1, 8));
      sel = $urandom_range(0, 19);
      if (sel == 0) h_data = '0;
      else if (sel == 1) h_data = CFG_DW'($urandom_range(4096, 8191));
      else if (sel < 6) h_data = CFG_DW'($urandom_range(9, 40));
      else h_data = CFG_DW'($urandom_range(1, 8));
      r_val = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 15);
      r_data = CFG_DW'(($urandom_range(0, 511) << RADIUS_IN_W) | r_val);
      ew = clamp_dim(w_data, MAX_W);
      eh = clamp_dim(h_data, MAX_H);
      frame_len = (ew + r_val) * (eh + r_val);
      if (frame_len <= 40 && $urandom_range(0, 9) < 7)
        count = frame_len + $urandom_range(0, frame_len);
      else
        count = $urandom_range(1, 40);
      no_gap = ($urandom_range(0, 4) == 0);
      run_phase(w_data, h_data, r_data, count, 1'b0);
      random_items += count;
    end

    in_valid <= 1'b0;
    while (expected_sums.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/bsf_pkg.sv
rtl/bsf_ctrl.sv
rtl/bsf_dp.sv
rtl/box_sum_filter_2d.sv
rtl/bsf_checker.sv
verif/testbench.sv
